// ----- hw/rtl/bdp_pkg.sv -----
// Shared types, constants and helpers of the branch direction predictor.
package bdp_pkg;

	localparam int IDX_W   = 10;
	localparam int DEPTH   = 1 << IDX_W;
	localparam int GHIST_W = 10;
	localparam int HLEN_W  = 4;
	localparam int MODE_W  = 3;
	localparam int CTR_W   = 2;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 3;

	localparam logic [ADDR_W-1:0] ADDR_MODE = 3'd0;
	localparam logic [ADDR_W-1:0] ADDR_HLEN = 3'd4;

	localparam logic OP_PREDICT = 1'b0;
	localparam logic OP_UPDATE  = 1'b1;

	localparam logic [CTR_W-1:0] CTR_ZERO    = 2'd0;
	localparam logic [CTR_W-1:0] CTR_WEAK_NT = 2'd1;
	localparam logic [CTR_W-1:0] CTR_WEAK_T  = 2'd2;
	localparam logic [CTR_W-1:0] CTR_MAX     = 2'd3;

	typedef logic [CTR_W-1:0] ctr_t;
	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_STATIC = 3'd0,
		MODE_BIM1   = 3'd1,
		MODE_BIM2   = 3'd2,
		MODE_GSHARE = 3'd3,
		MODE_TOURN  = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic clear;
		logic restart;
	} dp_cmd_t;

	typedef struct packed {
		logic mode_wr;
		logic clear_done;
		logic exec_blocked;
	} dp_stat_t;

	function automatic ctr_t sat_step(ctr_t c, logic up);
		ctr_t r;
		r = c;
		if (up) begin
			if (c != CTR_MAX) r = c + 2'd1;
		end else begin
			if (c != CTR_ZERO) r = c - 2'd1;
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/configurable_branch_direction_predictor_unit.sv -----
// Top level of the configurable branch direction predictor.
//
//  channel  | signals                                      | direction
//  request  | in_valid/in_ready, operation, branch_pc,     | in
//           | outcome_taken                                |
//  result   | out_valid/out_ready, predict_taken           | out
//  config   | psel/penable/pwrite/paddr/pwdata/prdata      | in/out
//
// Each request is accepted with the table read, then executed and written back;
// the registered read of the counter RAMs is the reason for this split.
// After reset and after every predictor_mode write a clearing pass over all 1024
// table entries (one table entry per cycle) runs with in_ready low.
// A predict transaction waits in execute while the previous result is not taken.
module configurable_branch_direction_predictor_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       operation,
	input  logic [31:0]                branch_pc,
	input  logic                       outcome_taken,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       predict_taken,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [bdp_pkg::ADDR_W-1:0] paddr,
	input  logic [bdp_pkg::DATA_W-1:0] pwdata,
	output logic [bdp_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);

	bdp_pkg::dp_cmd_t  cmd;
	bdp_pkg::dp_stat_t stat;

	assign pready = 1'b1;

	bdp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.stat(stat), .cmd(cmd)
	);

	bdp_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.operation(operation), .branch_pc(branch_pc), .outcome_taken(outcome_taken),
		.out_ready(out_ready), .out_valid(out_valid), .predict_taken(predict_taken),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata)
	);

endmodule

// ----- hw/rtl/bdp_ram.sv -----
// Generic single write port, single read port RAM with registered read.
module bdp_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/bdp_ctrl.sv -----
// Controller: sequences table clearing, request capture and execution.
module bdp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bdp_pkg::dp_stat_t  stat,
	output bdp_pkg::dp_cmd_t   cmd
);

	bdp_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bdp_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		cmd         = '0;
		cmd.restart = stat.mode_wr;
		unique case (state_q)
			bdp_pkg::ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clear_done) state_d = bdp_pkg::ST_IDLE;
			end
			bdp_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = bdp_pkg::ST_EXEC;
				end
			end
			bdp_pkg::ST_EXEC: begin
				if (!stat.exec_blocked) begin
					cmd.exec = 1'b1;
					state_d  = bdp_pkg::ST_IDLE;
				end
			end
			default: state_d = bdp_pkg::ST_CLEAR;
		endcase
		if (stat.mode_wr) state_d = bdp_pkg::ST_CLEAR;
	end

endmodule

// ----- hw/rtl/bdp_datapath.sv -----
// Datapath: config registers, history, counter tables, update logic, result register.
module bdp_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bdp_pkg::dp_cmd_t               cmd,
	output bdp_pkg::dp_stat_t              stat,
	input  logic                           operation,
	input  logic [31:0]                    branch_pc,
	input  logic                           outcome_taken,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic                           predict_taken,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bdp_pkg::ADDR_W-1:0]     paddr,
	input  logic [bdp_pkg::DATA_W-1:0]     pwdata,
	output logic [bdp_pkg::DATA_W-1:0]     prdata
);

	localparam logic [bdp_pkg::HLEN_W-1:0] HLEN_MAX = bdp_pkg::HLEN_W'(bdp_pkg::GHIST_W);

	logic [bdp_pkg::MODE_W-1:0]  mode_q;
	logic [bdp_pkg::HLEN_W-1:0]  hlen_q;
	logic [bdp_pkg::GHIST_W-1:0] hist_q;
	bdp_pkg::idx_t               clr_cnt_q;
	logic                        out_valid_q;
	logic                        pred_q;

	bdp_pkg::idx_t bi_q, gi_q, ci_q;
	logic          op_q, taken_q;

	logic                                      cfg_wr, hlen_wr;
	logic [bdp_pkg::HLEN_W-1:0]                len_sat;
	logic [bdp_pkg::GHIST_W-1:0]               hmask;
	logic [bdp_pkg::GHIST_W+bdp_pkg::IDX_W-1:0] hext;
	bdp_pkg::idx_t                             hist_idx, rd_bi, rd_gi;
	bdp_pkg::ctr_t                             bc, gc, cc, bim_fill;
	logic                                      pred;
	logic                                      upd, push;
	logic                                      bim_we_x, gsh_we_x, cho_we_x;
	bdp_pkg::ctr_t                             bim_wd_x, gsh_wd_x, cho_wd_x;
	logic                                      bim_we, gsh_we, cho_we;
	bdp_pkg::ctr_t                             bim_wd, gsh_wd, cho_wd;
	bdp_pkg::idx_t                             bim_wa, gsh_wa, cho_wa;
	logic                                      bim_ok, gsh_ok;

	assign cfg_wr       = psel & penable & pwrite;
	assign stat.mode_wr = cfg_wr && (paddr == bdp_pkg::ADDR_MODE);
	assign hlen_wr      = cfg_wr && (paddr == bdp_pkg::ADDR_HLEN);

	always_comb begin
		case (paddr)
			bdp_pkg::ADDR_MODE: prdata = bdp_pkg::DATA_W'(mode_q);
			bdp_pkg::ADDR_HLEN: prdata = bdp_pkg::DATA_W'(hlen_q);
			default:            prdata = '0;
		endcase
	end

	// index generation from the request ports
	always_comb begin
		len_sat = (hlen_q > HLEN_MAX) ? HLEN_MAX : hlen_q;
		for (int i = 0; i < bdp_pkg::GHIST_W; i++) begin
			hmask[i] = hist_q[i] & (i < int'(len_sat));
		end
		hext     = {{bdp_pkg::IDX_W{1'b0}}, hmask};
		hist_idx = hext[bdp_pkg::IDX_W-1:0];
		rd_bi    = branch_pc[bdp_pkg::IDX_W+1:2];
		rd_gi    = rd_bi ^ hist_idx;
	end

	always_comb begin
		case (mode_q) inside
			bdp_pkg::MODE_BIM2, bdp_pkg::MODE_GSHARE, bdp_pkg::MODE_TOURN:
				bim_fill = bdp_pkg::CTR_WEAK_T;
			default: bim_fill = bdp_pkg::CTR_ZERO;
		endcase
	end

	// prediction and training
	always_comb begin
		pred     = 1'b0;
		push     = 1'b0;
		bim_we_x = 1'b0;
		gsh_we_x = 1'b0;
		cho_we_x = 1'b0;
		bim_wd_x = bdp_pkg::sat_step(bc, taken_q);
		gsh_wd_x = bdp_pkg::sat_step(gc, taken_q);
		bim_ok   = (bc[1] == taken_q);
		gsh_ok   = (gc[1] == taken_q);
		cho_wd_x = bdp_pkg::sat_step(cc, gsh_ok);
		upd      = cmd.exec && (op_q == bdp_pkg::OP_UPDATE);
		case (mode_q)
			bdp_pkg::MODE_BIM1: begin
				pred     = (bc != bdp_pkg::CTR_ZERO);
				bim_we_x = upd;
				bim_wd_x = {1'b0, taken_q};
			end
			bdp_pkg::MODE_BIM2: begin
				pred     = bc[1];
				bim_we_x = upd;
			end
			bdp_pkg::MODE_GSHARE: begin
				pred     = gc[1];
				gsh_we_x = upd;
				push     = upd;
			end
			bdp_pkg::MODE_TOURN: begin
				pred     = cc[1] ? gc[1] : bc[1];
				bim_we_x = upd;
				gsh_we_x = upd;
				cho_we_x = upd && (bim_ok != gsh_ok);
				push     = upd;
			end
			default: pred = 1'b0;
		endcase
	end

	always_comb begin
		if (cmd.clear) begin
			bim_we = 1'b1;
			gsh_we = 1'b1;
			cho_we = 1'b1;
			bim_wd = bim_fill;
			gsh_wd = bdp_pkg::CTR_WEAK_T;
			cho_wd = bdp_pkg::CTR_WEAK_NT;
			bim_wa = clr_cnt_q;
			gsh_wa = clr_cnt_q;
			cho_wa = clr_cnt_q;
		end else begin
			bim_we = bim_we_x;
			gsh_we = gsh_we_x;
			cho_we = cho_we_x;
			bim_wd = bim_wd_x;
			gsh_wd = gsh_wd_x;
			cho_wd = cho_wd_x;
			bim_wa = bi_q;
			gsh_wa = gi_q;
			cho_wa = ci_q;
		end
	end

	bdp_ram #(.WIDTH(bdp_pkg::CTR_W), .DEPTH(bdp_pkg::DEPTH)) u_bim (
		.clk(clk), .we(bim_we), .waddr(bim_wa), .wdata(bim_wd),
		.re(cmd.load), .raddr(rd_bi), .rdata(bc)
	);

	bdp_ram #(.WIDTH(bdp_pkg::CTR_W), .DEPTH(bdp_pkg::DEPTH)) u_gsh (
		.clk(clk), .we(gsh_we), .waddr(gsh_wa), .wdata(gsh_wd),
		.re(cmd.load), .raddr(rd_gi), .rdata(gc)
	);

	bdp_ram #(.WIDTH(bdp_pkg::CTR_W), .DEPTH(bdp_pkg::DEPTH)) u_cho (
		.clk(clk), .we(cho_we), .waddr(cho_wa), .wdata(cho_wd),
		.re(cmd.load), .raddr(hist_idx), .rdata(cc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= '0;
			hlen_q      <= '0;
			hist_q      <= '0;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (stat.mode_wr) mode_q <= pwdata[bdp_pkg::MODE_W-1:0];
			if (hlen_wr) hlen_q <= pwdata[bdp_pkg::HLEN_W-1:0];
			if (stat.mode_wr) begin
				hist_q <= '0;
			end else if (push) begin
				hist_q <= {hist_q[bdp_pkg::GHIST_W-2:0], taken_q};
			end
			if (cmd.restart) begin
				clr_cnt_q <= '0;
			end else if (cmd.clear) begin
				clr_cnt_q <= clr_cnt_q + bdp_pkg::idx_t'(1);
			end
			if (cmd.exec && (op_q == bdp_pkg::OP_PREDICT)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= operation;
			taken_q <= outcome_taken;
			bi_q    <= rd_bi;
			gi_q    <= rd_gi;
			ci_q    <= hist_idx;
		end
		if (cmd.exec && (op_q == bdp_pkg::OP_PREDICT)) pred_q <= pred;
	end

	assign stat.clear_done   = &clr_cnt_q;
	assign stat.exec_blocked = (op_q == bdp_pkg::OP_PREDICT) && out_valid_q && !out_ready;
	assign out_valid         = out_valid_q;
	assign predict_taken     = pred_q;

endmodule

// ----- hw/rtl/bdp_checker.sv -----
// Port-level checker for the branch direction predictor, bound to the top level.
module bdp_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       operation,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic                       predict_taken,
	input logic                       psel,
	input logic                       penable,
	input logic                       pwrite,
	input logic [bdp_pkg::ADDR_W-1:0] paddr
);

	logic in_acc, mode_wr;

	assign in_acc  = in_valid & in_ready;
	assign mode_wr = psel & penable & pwrite & (paddr == bdp_pkg::ADDR_MODE);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(predict_taken))
		else $error("result changed while stalled");

	a_clear_on_mode: assert property (@(posedge clk) disable iff (!arst_n)
		mode_wr |=> !in_ready)
		else $error("request accepted right after mode write");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("second transaction accepted during execute");

	a_update_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (operation == bdp_pkg::OP_UPDATE) && !out_valid |-> ##2 !out_valid)
		else $error("update produced a result");

	a_predict_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (operation == bdp_pkg::OP_PREDICT) && !out_valid |-> ##2 out_valid)
		else $error("predict produced no result");

endmodule

bind configurable_branch_direction_predictor_unit bdp_checker u_bdp_checker (.*);

// ----- bench/tb.sv -----
// Testbench of the branch direction predictor: directed table, then random mode phases.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bdp_pkg::*;

	localparam int WATCH_LIMIT = 5000;
	localparam int HOLD_CYCLES = 200;
	localparam int NPHASE      = 13;
	localparam int PHASE_ITEMS = 58;
	localparam int DRAIN       = 8;

	localparam logic [MODE_W-1:0] MODE_RSVD5 = 3'd5;
	localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
	localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;
	localparam logic [HLEN_W-1:0] HLEN_NONE  = 4'd0;
	localparam logic [HLEN_W-1:0] HLEN_FULL  = 4'd10;
	localparam logic [HLEN_W-1:0] HLEN_MAX   = 4'd15;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		logic [ADDR_W-1:0] addr;
		logic [3:0]        val;
		logic              op;
		logic [31:0]       pc;
		logic              tk;
		logic              typed;
		logic              dir;
	} row_t;

	logic                clk;
	logic                arst_n        = 1'b0;
	logic                in_valid      = 1'b0;
	logic                in_ready;
	logic                operation     = OP_PREDICT;
	logic [31:0]         branch_pc     = '0;
	logic                outcome_taken = 1'b0;
	logic                out_valid;
	logic                out_ready     = 1'b0;
	logic                predict_taken;
	logic                psel          = 1'b0;
	logic                penable       = 1'b0;
	logic                pwrite        = 1'b0;
	logic [ADDR_W-1:0]   paddr         = '0;
	logic [DATA_W-1:0]   pwdata        = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	configurable_branch_direction_predictor_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .branch_pc(branch_pc), .outcome_taken(outcome_taken),
		.out_valid(out_valid), .out_ready(out_ready), .predict_taken(predict_taken),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state
	ctr_t               bim_tab [DEPTH];
	ctr_t               gsh_tab [DEPTH];
	ctr_t               cho_tab [DEPTH];
	logic [GHIST_W-1:0] ghist;
	logic [MODE_W-1:0]  cur_mode;
	logic [HLEN_W-1:0]  cur_hlen;

	logic pending_dirs [$];
	int   errs         = 0;
	int   quiet_cycles = 0;
	int   stall_left   = 0;
	int   hold_reqs    = 0;
	int   hold_done    = 0;
	bit   idle_on      = 1'b1;

	row_t dir_tab [$] = '{
		'{ROW_ITEM, ADDR_MODE, 4'd0, OP_PREDICT, 32'h0000_0000, 1'b0, 1'b1, 1'b0},
		'{ROW_ITEM, ADDR_MODE, 4'd0, OP_PREDICT, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0},
		'{ROW_ITEM, ADDR_MODE, 4'd0, OP_UPDATE,  32'h0000_0000, 1'b1, 1'b0, 1'b0},
		'{ROW_ITEM, ADDR_MODE, 4'd0, OP_PREDICT, 32'h0000_0000, 1'b0, 1'b1, 1'b0},
		'{ROW_CFG,  ADDR_MODE, {1'b0, MODE_BIM1}, OP_PREDICT, 32'h0, 1'b0, 1'b0, 1'b0},
		'{ROW_ITEM, ADDR_MODE, 4'd0, OP_PREDICT, 32'h0000_0000, 1'b0, 1'b1, 1'b0},
		'{ROW_ITEM, ADDR_MODE, 4'd0, OP_UPDATE,  32'h0000_0000, 1'b1, 1'b0, 1'b0},
		'{ROW_ITEM, ADDR_MODE, 4'd0, OP_PREDICT, 32'h0000_0000, 1'b0, 1'b1, 1'b1},
		'{ROW_ITEM, ADDR_MODE, 4'd0, OP_UPDATE,  32'hFFFF_FFFC, 1'b0, 1'b0, 1'b0},
		'{ROW_ITEM, ADDR_MODE, 4'd0, OP_PREDICT, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0},
		'{ROW_CFG,  ADDR_MODE, {1'b0, MODE_BIM2}, OP_PREDICT, 32'h0, 1'b0, 1'b0, 1'b0},
		'{ROW_ITEM, ADDR_MODE, 4'd0, OP_PREDICT, 32'h0000_0004, 1'b0, 1'b1, 1'b1},
		'{ROW_ITEM, ADDR_MODE, 4'd0, OP_UPDATE,  32'h0000_0004, 1'b1, 1'b0, 1'b0},
		'{ROW_ITEM, ADDR_MODE, 4'd0, OP_UPDATE,  32'h0000_0004, 1'b1, 1'b0, 1'b0},
		'{ROW_ITEM, ADDR_MODE, 4'd0, OP_UPDATE,  32'h0000_0004, 1'b1, 1'b0, 1'b0},
		'{ROW_ITEM, ADDR_MODE, 4'd0, OP_UPDATE,  32'h0000_0004, 1'b0, 1'b0, 1'b0},
		'{ROW_ITEM, ADDR_MODE, 4'd0, OP_PREDICT, 32'h0000_0004, 1'b0, 1'b0, 1'b0},
		'{ROW_CFG,  ADDR_HLEN, HLEN_MAX, OP_PREDICT, 32'h0, 1'b0, 1'b0, 1'b0},
		'{ROW_CFG,  ADDR_MODE, {1'b0, MODE_GSHARE}, OP_PREDICT, 32'h0, 1'b0, 1'b0, 1'b0},
		'{ROW_ITEM, ADDR_MODE, 4'd0, OP_PREDICT, 32'h0000_0008, 1'b0, 1'b1, 1'b1},
		'{ROW_ITEM, ADDR_MODE, 4'd0, OP_UPDATE,  32'h0000_0008, 1'b0, 1'b0, 1'b0},
		'{ROW_ITEM, ADDR_MODE, 4'd0, OP_PREDICT, 32'h0000_0008, 1'b0, 1'b0, 1'b0},
		'{ROW_CFG,  ADDR_MODE, {1'b0, MODE_TOURN}, OP_PREDICT, 32'h0, 1'b0, 1'b0, 1'b0},
		'{ROW_ITEM, ADDR_MODE, 4'd0, OP_PREDICT, 32'h0000_0010, 1'b0, 1'b1, 1'b1},
		'{ROW_ITEM, ADDR_MODE, 4'd0, OP_UPDATE,  32'h0000_0010, 1'b0, 1'b0, 1'b0},
		'{ROW_ITEM, ADDR_MODE, 4'd0, OP_UPDATE,  32'h0000_0010, 1'b1, 1'b0, 1'b0},
		'{ROW_ITEM, ADDR_MODE, 4'd0, OP_PREDICT, 32'h0000_0010, 1'b0, 1'b0, 1'b0},
		'{ROW_CFG,  ADDR_MODE, {1'b0, MODE_RSVD7}, OP_PREDICT, 32'h0, 1'b0, 1'b0, 1'b0},
		'{ROW_ITEM, ADDR_MODE, 4'd0, OP_PREDICT, 32'h0000_0000, 1'b0, 1'b1, 1'b0},
		'{ROW_ITEM, ADDR_MODE, 4'd0, OP_UPDATE,  32'h0000_0000, 1'b1, 1'b0, 1'b0},
		'{ROW_ITEM, ADDR_MODE, 4'd0, OP_PREDICT, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0}
	};

	logic [MODE_W-1:0] phase_mode [NPHASE] = '{
		MODE_BIM2, MODE_TOURN, MODE_GSHARE, MODE_BIM1, MODE_STATIC, MODE_TOURN, MODE_RSVD5,
		MODE_GSHARE, MODE_BIM2, MODE_RSVD7, MODE_TOURN, MODE_RSVD6, MODE_TOURN
	};

	function automatic void refill_tables();
		ctr_t fill;
		fill = (cur_mode == MODE_BIM2 || cur_mode == MODE_GSHARE || cur_mode == MODE_TOURN) ?
			CTR_WEAK_T : CTR_ZERO;
		for (int i = 0; i < DEPTH; i++) begin
			bim_tab[i] = fill;
			gsh_tab[i] = CTR_WEAK_T;
			cho_tab[i] = CTR_WEAK_NT;
		end
		ghist = '0;
	endfunction

	function automatic ctr_t nudge(ctr_t c, logic up);
		if (up)
			return (c == CTR_MAX) ? c : ctr_t'(c + 1'b1);
		return (c == CTR_ZERO) ? c : ctr_t'(c - 1'b1);
	endfunction

	function automatic idx_t history_bits();
		logic [GHIST_W:0] m;
		int               len;
		len = (cur_hlen > HLEN_FULL) ? GHIST_W : int'(cur_hlen);
		m = (GHIST_W+1)'(1) << len;
		m = m - 1'b1;
		return idx_t'(ghist & m[GHIST_W-1:0]);
	endfunction

	function automatic logic predicted_direction(logic [31:0] pc);
		idx_t bi, gi, ci;
		logic r;
		bi = pc[IDX_W+1:2];
		ci = history_bits();
		gi = bi ^ ci;
		case (cur_mode)
			MODE_BIM1:   r = bim_tab[bi] != CTR_ZERO;
			MODE_BIM2:   r = bim_tab[bi] >= CTR_WEAK_T;
			MODE_GSHARE: r = gsh_tab[gi] >= CTR_WEAK_T;
			MODE_TOURN:  r = (cho_tab[ci] >= CTR_WEAK_T) ? (gsh_tab[gi] >= CTR_WEAK_T) :
				(bim_tab[bi] >= CTR_WEAK_T);
			default:     r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic void learn_outcome(logic [31:0] pc, logic tk);
		idx_t bi, gi, ci;
		logic bim_ok, gsh_ok;
		bi = pc[IDX_W+1:2];
		ci = history_bits();
		gi = bi ^ ci;
		case (cur_mode)
			MODE_BIM1: bim_tab[bi] = {1'b0, tk};
			MODE_BIM2: bim_tab[bi] = nudge(bim_tab[bi], tk);
			MODE_GSHARE: begin
				gsh_tab[gi] = nudge(gsh_tab[gi], tk);
				ghist = {ghist[GHIST_W-2:0], tk};
			end
			MODE_TOURN: begin
				bim_ok = (bim_tab[bi] >= CTR_WEAK_T) == tk;
				gsh_ok = (gsh_tab[gi] >= CTR_WEAK_T) == tk;
				if (bim_ok != gsh_ok)
					cho_tab[ci] = nudge(cho_tab[ci], gsh_ok);
				bim_tab[bi] = nudge(bim_tab[bi], tk);
				gsh_tab[gi] = nudge(gsh_tab[gi], tk);
				ghist = {ghist[GHIST_W-2:0], tk};
			end
			default: ;
		endcase
	endfunction

	// entered and left at a falling edge
	task automatic send_item(logic op, logic [31:0] pc, logic tk, logic typed, logic dir);
		int gap;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid      <= 1'b1;
		operation     <= op;
		branch_pc     <= pc;
		outcome_taken <= tk;
		do @(posedge clk); while (!in_ready);
		if (op == OP_PREDICT)
			pending_dirs.push_back(typed ? dir : predicted_direction(pc));
		else
			learn_outcome(pc, tk);
		@(negedge clk);
	endtask

	task automatic cfg_write(logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
		in_valid <= 1'b0;
		while (pending_dirs.size() != 0) @(posedge clk);
		// updates still in flight give no result
		repeat (4) @(posedge clk);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= a;
		pwdata  <= d;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (a == ADDR_MODE) begin
			cur_mode = d[MODE_W-1:0];
			refill_tables();
		end else begin
			cur_hlen = d[HLEN_W-1:0];
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// receiver side
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else if (hold_reqs != hold_done) begin
			hold_done++;
			stall_left = HOLD_CYCLES - 1;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 3);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_result
		logic want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_dirs.size() == 0) begin
				$error("predict_taken: unexpected transaction, value %0b", predict_taken);
				errs++;
			end else begin
				want = pending_dirs.pop_front();
				if (predict_taken !== want) begin
					$error("predict_taken: expected %0b, actual %0b", want, predict_taken);
					errs++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(psel && penable && pwrite && pready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCH_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	initial begin : stimulus
		logic [31:0]       pool [8];
		int                bias [8];
		int                k;
		logic [31:0]       pc;
		logic              tk, op;
		logic [HLEN_W-1:0] hl;
		cur_mode = MODE_STATIC;
		cur_hlen = HLEN_NONE;
		refill_tables();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ROW_CFG)
				cfg_write(dir_tab[i].addr, DATA_W'(dir_tab[i].val));
			else
				send_item(dir_tab[i].op, dir_tab[i].pc, dir_tab[i].tk,
					dir_tab[i].typed, dir_tab[i].dir);
		end

		for (int p = 0; p < NPHASE; p++) begin
			idle_on = (p < NPHASE - 2);
			case (p % 4)
				0:       hl = HLEN_NONE;
				1:       hl = HLEN_FULL;
				2:       hl = HLEN_MAX;
				default: hl = HLEN_W'($urandom_range(0, 15));
			endcase
			cfg_write(ADDR_HLEN, DATA_W'(hl));
			cfg_write(ADDR_MODE, DATA_W'(phase_mode[p]));
			for (int j = 0; j < 8; j++) begin
				pool[j] = $urandom();
				bias[j] = $urandom_range(0, 2) * 4 + 1;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 1 && n == 4)
					hold_reqs++;
				if (p == 5 && n == PHASE_ITEMS / 2) begin
					in_valid <= 1'b0;
					while (pending_dirs.size() != 0) @(posedge clk);
					@(negedge clk);
				end
				op = 1'($urandom_range(0, 1));
				if ($urandom_range(0, 6) == 0) begin
					pc = $urandom();
					tk = 1'($urandom_range(0, 1));
				end else begin
					k = $urandom_range(0, 7);
					if ($urandom_range(0, 40) == 0)
						pool[k] = $urandom();
					pc = pool[k];
					tk = ($urandom_range(0, 9) < bias[k]);
				end
				send_item(op, pc, tk, 1'b0, 1'b0);
			end
		end

		in_valid <= 1'b0;
		while (pending_dirs.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (errs == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
